@@ design/ptts_pkg.sv @@
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants for the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

  typedef logic [2:0] op_t;

  localparam op_t OP_TICK    = 3'd0;
  localparam op_t OP_CREATE  = 3'd1;
  localparam op_t OP_SUSPEND = 3'd2;
  localparam op_t OP_RESUME  = 3'd3;
  localparam op_t OP_DELETE  = 3'd4;

  localparam int OP_W     = 3;
  localparam int ID_W     = 3;
  localparam int PERIOD_W = 16;

  // due words reported per tick
  localparam int MAX_RESULTS = 8;
  localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
  typedef logic [RCNT_W-1:0] rcnt_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_RD    = 5'b00100,
    S_EV    = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic cap;    // capture input word, clear scan state
    logic rd;     // read period/countdown at scan index
    logic ev;     // commit evaluation of the current entry
    logic apply;  // edit one entry, push ack
    logic fin;    // push final word of a tick
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic tick_op;
    logic out_free;
    logic due_hit;
    logic pend_vld;
    logic scan_last;
  } sts_t;

endpackage

@@ design/ptts_if.sv @@
// ----------------------------------------------------------------------------
// ptts_in_if / ptts_out_if
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
interface ptts_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [2:0] task_id;
  logic [15:0] period;
  logic       handler_valid;

  modport source (output valid, output operation, output task_id, output period,
                  output handler_valid, input ready);
  modport sink   (input valid, input operation, input task_id, input period,
                  input handler_valid, output ready);
endinterface

interface ptts_out_if;
  logic       valid;
  logic       ready;
  logic       due;
  logic [2:0] due_task;
  logic       last;

  modport source (output valid, output due, output due_task, output last, input ready);
  modport sink   (input valid, input due, input due_task, input last, output ready);
endinterface

@@ design/ptts_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptts_ctrl
// Sequencer: accepts a word, runs an edit or a table scan, emits results.
// ----------------------------------------------------------------------------
module ptts_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ptts_pkg::sts_t  sts,
  output ptts_pkg::cmd_t  cmd
);

  ptts_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptts_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ptts_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ptts_pkg::S_START;
        end
      end
      ptts_pkg::S_START: begin
        if (sts.tick_op) begin
          cmd.rd    = 1'b1;
          state_nxt = ptts_pkg::S_EV;
        end else if (sts.out_free) begin
          cmd.apply = 1'b1;
          state_nxt = ptts_pkg::S_IDLE;
        end
      end
      ptts_pkg::S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ptts_pkg::S_EV;
      end
      ptts_pkg::S_EV: begin
        // a new due entry flushes the held one; wait if output is busy
        if (!(sts.due_hit && sts.pend_vld && !sts.out_free)) begin
          cmd.ev    = 1'b1;
          state_nxt = sts.scan_last ? ptts_pkg::S_FIN : ptts_pkg::S_RD;
        end
      end
      ptts_pkg::S_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ptts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ptts_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ design/ptts_dp.sv @@
// ----------------------------------------------------------------------------
// ptts_dp
// Task table, scan index, held due entry and output word register.
// ----------------------------------------------------------------------------
module ptts_dp #(
  parameter int TASK_COUNT = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ptts_pkg::cmd_t                 cmd,
  output ptts_pkg::sts_t                 sts,
  input  logic [ptts_pkg::OP_W-1:0]      op_i,
  input  logic [ptts_pkg::ID_W-1:0]      id_i,
  input  logic [ptts_pkg::PERIOD_W-1:0]  period_i,
  input  logic                           hv_i,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_due,
  output logic [ptts_pkg::ID_W-1:0]      out_due_task,
  output logic                           out_last
);

  localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_COUNT - 1);

  // captured word
  ptts_pkg::op_t                 op_r;
  logic [ptts_pkg::ID_W-1:0]     id_r;
  logic [ptts_pkg::PERIOD_W-1:0] per_r;
  logic                          hv_r;

  // table: period/countdown in RAM, flags in flops
  logic [ptts_pkg::PERIOD_W-1:0] per_mem [TASK_COUNT];
  logic [ptts_pkg::PERIOD_W-1:0] cnt_mem [TASK_COUNT];
  logic [ptts_pkg::PERIOD_W-1:0] per_q, cnt_q;
  logic [TASK_COUNT-1:0]         present_r, susp_r, cnt_vld_r;

  // scan state
  logic [IDX_W-1:0]              idx_r;
  ptts_pkg::rcnt_t               nrep_r;
  logic                          pend_vld_r;
  logic [IDX_W-1:0]              pend_id_r;

  // output word register
  logic                          out_valid_r, out_due_r, out_last_r;
  logic [ptts_pkg::ID_W-1:0]     out_task_r;

  logic                          id_ok;
  logic [IDX_W-1:0]              id_idx;
  logic                          eligible, cd_zero, due_hit, out_free;
  logic [ptts_pkg::PERIOD_W-1:0] cd, cnt_wdata;
  logic                          push_ev, push;
  logic                          push_due, push_last;
  logic [ptts_pkg::ID_W-1:0]     push_task;

  assign id_ok  = {{(32 - ptts_pkg::ID_W){1'b0}}, id_r} < 32'(TASK_COUNT);
  assign id_idx = IDX_W'(id_r);

  assign eligible  = present_r[idx_r] & ~susp_r[idx_r];
  // unwritten countdown (after reset or delete) reads as zero
  assign cd        = cnt_vld_r[idx_r] ? cnt_q : '0;
  assign cd_zero   = (cd == '0);
  assign due_hit   = eligible & cd_zero & (nrep_r < ptts_pkg::rcnt_t'(ptts_pkg::MAX_RESULTS));
  assign cnt_wdata = cd_zero ? per_q : cd - 1'b1;
  assign out_free  = ~out_valid_r | out_ready;

  assign sts.tick_op   = (op_r == ptts_pkg::OP_TICK);
  assign sts.out_free  = out_free;
  assign sts.due_hit   = due_hit;
  assign sts.pend_vld  = pend_vld_r;
  assign sts.scan_last = (idx_r == LAST_IDX);

  // held due entry leaves as a non-final word once the next one shows up
  assign push_ev = cmd.ev & due_hit & pend_vld_r;
  assign push    = push_ev | cmd.apply | cmd.fin;

  always_comb begin
    push_due  = 1'b0;
    push_task = '0;
    push_last = 1'b1;
    if (push_ev) begin
      push_due  = 1'b1;
      push_task = ptts_pkg::ID_W'(pend_id_r);
      push_last = 1'b0;
    end else if (cmd.fin && pend_vld_r) begin
      push_due  = 1'b1;
      push_task = ptts_pkg::ID_W'(pend_id_r);
    end
  end

  // captured word
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r  <= op_i;
      id_r  <= id_i;
      per_r <= period_i;
      hv_r  <= hv_i;
    end
  end

  // table RAMs
  always_ff @(posedge clk) begin
    if (cmd.apply && id_ok && (op_r == ptts_pkg::OP_CREATE)) begin
      per_mem[id_idx] <= per_r;
    end
    if (cmd.ev && eligible) begin
      cnt_mem[idx_r] <= cnt_wdata;
    end
    if (cmd.rd) begin
      per_q <= per_mem[idx_r];
      cnt_q <= cnt_mem[idx_r];
    end
  end

  // flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      susp_r    <= '0;
      cnt_vld_r <= '0;
    end else begin
      if (cmd.ev && eligible) begin
        cnt_vld_r[idx_r] <= 1'b1;
      end
      if (cmd.apply && id_ok) begin
        unique case (op_r)
          ptts_pkg::OP_CREATE:  present_r[id_idx] <= hv_r;
          ptts_pkg::OP_SUSPEND: susp_r[id_idx]    <= 1'b1;
          ptts_pkg::OP_RESUME:  susp_r[id_idx]    <= 1'b0;
          ptts_pkg::OP_DELETE: begin
            present_r[id_idx] <= 1'b0;
            susp_r[id_idx]    <= 1'b0;
            cnt_vld_r[id_idx] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      nrep_r     <= '0;
      pend_vld_r <= 1'b0;
    end else if (cmd.cap) begin
      idx_r      <= '0;
      nrep_r     <= '0;
      pend_vld_r <= 1'b0;
    end else if (cmd.fin) begin
      pend_vld_r <= 1'b0;
    end else if (cmd.ev) begin
      if (idx_r != LAST_IDX) begin
        idx_r <= idx_r + 1'b1;
      end
      if (due_hit) begin
        nrep_r     <= nrep_r + 1'b1;
        pend_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ev && due_hit) begin
      pend_id_r <= idx_r;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_due_r  <= push_due;
      out_task_r <= push_task;
      out_last_r <= push_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_due      = out_due_r;
  assign out_due_task = out_task_r;
  assign out_last     = out_last_r;

endmodule

@@ design/periodic_task_tick_scheduler.sv @@
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Time-triggered cooperative scheduler: task table with tick-driven countdowns.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one word per operation (tick, create, suspend, resume, delete),
//            taken when valid and ready are both high. ready is high only
//            while the sequencer is idle; one word is worked at a time.
//   out_ch : result words. A tick gives one word per due task in id order
//            (at most eight), or one not-due word; every other operation
//            gives one acknowledge word. last marks the final word.
//   Steps:   an edit is captured, then applied as its acknowledge is loaded
//            into the output register. A tick walks the table entry by entry
//            (RAM read, then evaluate/write), then pushes the final word.
//   The next word is taken only once the sequencer is back to idle.
//   A due word is held until the next due entry or the end of the scan so
//   that last can be set; words leave through an output register, so the
//   next operation is accepted while the final word still waits.
//   Receiver stall: the scan pauses on a due entry while the previous word
//   is still unread; nothing is dropped.
//   Reset (synchronous, active low): all tasks absent, ready, countdowns zero;
//   periods are not cleared but set by create; no clearing pass is needed.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler #(
  parameter int TASK_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  ptts_in_if.sink     in_ch,
  ptts_out_if.source  out_ch
);

  ptts_pkg::cmd_t cmd;
  ptts_pkg::sts_t sts;

  // sequencer
  ptts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table, scan state and output register
  ptts_dp #(
    .TASK_COUNT (TASK_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .op_i         (in_ch.operation),
    .id_i         (in_ch.task_id),
    .period_i     (in_ch.period),
    .hv_i         (in_ch.handler_valid),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_due      (out_ch.due),
    .out_due_task (out_ch.due_task),
    .out_last     (out_ch.last)
  );

endmodule

@@ design/ptts_checker.sv @@
// ----------------------------------------------------------------------------
// ptts_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module ptts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_due,
  input logic [2:0] out_due_task,
  input logic       out_last
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_due) &&
      $stable(out_due_task) && $stable(out_last))
    else $error("result word changed while stalled");

  // a not-due word always ends its operation and names task zero
  a_notdue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_due |-> out_last && (out_due_task == 3'd0))
    else $error("not-due word without last or with task id");

  // one operation at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_due      (out_ch.due),
  .out_due_task (out_ch.due_task),
  .out_last     (out_ch.last)
);

@@ test/ptts_sched_checker.sv @@
// ----------------------------------------------------------------------------
// ptts_sched_checker
// Watches the operation and result channels of the tick scheduler, keeps its
// own copy of the task table, predicts every result word and compares.
// ----------------------------------------------------------------------------
module ptts_sched_checker #(
  parameter int TASK_COUNT = 8
) (
  input  logic clk,
  input  logic rst_n,
  ptts_in_if   in_mon,
  ptts_out_if  out_mon,
  output int   mismatches,
  output int   words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                      due;
    logic [ptts_pkg::ID_W-1:0] due_task;
    logic                      last;
  } sched_word_t;

  logic [ptts_pkg::PERIOD_W-1:0] period_tbl    [TASK_COUNT];
  logic [ptts_pkg::PERIOD_W-1:0] countdown_tbl [TASK_COUNT];
  logic                          present_tbl   [TASK_COUNT];
  logic                          suspended_tbl [TASK_COUNT];

  sched_word_t sched_words_q[$];
  int          fail_count;

  // one acknowledge / not-due word
  function automatic sched_word_t ack_word();
    sched_word_t w;
    w.due      = 1'b0;
    w.due_task = '0;
    w.last     = 1'b1;
    return w;
  endfunction

  // Apply one operation word to the table copy, queue the words it causes.
  function void schedule_step(input ptts_pkg::op_t op,
                              input logic [ptts_pkg::ID_W-1:0] id,
                              input logic [ptts_pkg::PERIOD_W-1:0] per,
                              input logic hv);
    sched_word_t hits [ptts_pkg::MAX_RESULTS];
    int          n_hit;
    n_hit = 0;
    if (op == ptts_pkg::OP_TICK) begin
      for (int i = 0; i < TASK_COUNT; i++) begin
        if (present_tbl[i] && !suspended_tbl[i]) begin
          if (countdown_tbl[i] == '0) begin
            countdown_tbl[i] = period_tbl[i];
            // beyond eight due entries: reload only, no word
            if (n_hit < ptts_pkg::MAX_RESULTS) begin
              hits[n_hit].due      = 1'b1;
              hits[n_hit].due_task = ptts_pkg::ID_W'(i);
              hits[n_hit].last     = 1'b0;
              n_hit++;
            end
          end else begin
            countdown_tbl[i] = countdown_tbl[i] - 1'b1;
          end
        end
      end
      if (n_hit == 0) begin
        sched_words_q.push_back(ack_word());
      end else begin
        hits[n_hit-1].last = 1'b1;
        for (int k = 0; k < n_hit; k++) sched_words_q.push_back(hits[k]);
      end
    end else begin
      if (int'(id) < TASK_COUNT) begin
        case (op)
          ptts_pkg::OP_CREATE: begin
            period_tbl[id]  = per;
            present_tbl[id] = hv;
          end
          ptts_pkg::OP_SUSPEND: suspended_tbl[id] = 1'b1;
          ptts_pkg::OP_RESUME:  suspended_tbl[id] = 1'b0;
          ptts_pkg::OP_DELETE: begin
            period_tbl[id]    = '0;
            countdown_tbl[id] = '0;
            present_tbl[id]   = 1'b0;
            suspended_tbl[id] = 1'b0;
          end
          default: ;
        endcase
      end
      sched_words_q.push_back(ack_word());
    end
  endfunction

  task automatic note_mismatch(input string what, input sched_word_t exp_w,
                               input sched_word_t got_w);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t MISMATCH %s: expected due=%0b task=%0d last=%0b,",
               $realtime, what, exp_w.due, exp_w.due_task, exp_w.last,
               " got due=%0b task=%0d last=%0b",
               got_w.due, got_w.due_task, got_w.last);
  endtask

  always @(posedge clk) begin
    sched_word_t got_w;
    sched_word_t exp_w;
    if (!rst_n) begin
      for (int i = 0; i < TASK_COUNT; i++) begin
        period_tbl[i]    = '0;
        countdown_tbl[i] = '0;
        present_tbl[i]   = 1'b0;
        suspended_tbl[i] = 1'b0;
      end
      sched_words_q.delete();
      fail_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        schedule_step(in_mon.operation, in_mon.task_id, in_mon.period,
                      in_mon.handler_valid);
      if (out_mon.valid && out_mon.ready) begin
        got_w.due      = out_mon.due;
        got_w.due_task = out_mon.due_task;
        got_w.last     = out_mon.last;
        if (sched_words_q.size() == 0) begin
          note_mismatch("unexpected word", ack_word(), got_w);
        end else begin
          exp_w = sched_words_q.pop_front();
          if (got_w.due !== exp_w.due || got_w.due_task !== exp_w.due_task ||
              got_w.last !== exp_w.last)
            note_mismatch("word", exp_w, got_w);
        end
      end
    end
    mismatches    <= fail_count;
    words_pending <= sched_words_q.size();
  end

endmodule

@@ test/tb_periodic_task_tick_scheduler.sv @@
// ----------------------------------------------------------------------------
// tb_periodic_task_tick_scheduler
// Drives create/suspend/resume/delete/tick words into the scheduler with
// random source gaps and sink stalls; a checker alongside predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module tb_periodic_task_tick_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_TASKS    = 8;
  localparam int RANDOM_WORDS = 140;
  // room for a last tick scan; allow for stalls on top
  localparam int DRAIN_CYCLES = 60;

  // unused operation codes, accepted and acknowledged without effect
  localparam ptts_pkg::op_t OP_SPARE_5 = 3'd5;
  localparam ptts_pkg::op_t OP_SPARE_7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   words_pending;
  // when set, neither side idles
  logic steady = 1'b0;

  ptts_in_if  in_ch();
  ptts_out_if out_ch();

  periodic_task_tick_scheduler #(.TASK_COUNT(NUM_TASKS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ptts_sched_checker #(.TASK_COUNT(NUM_TASKS)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result sink: stalls on roughly 28% of cycles, never while steady.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 28);
    end
  end

  // Present one operation word and hold it until the block takes it.
  // Idle cycles go in front of the word; valid stays high across
  // back-to-back words so it is never dropped and raised in one step.
  task automatic issue_op(input ptts_pkg::op_t op,
                          input logic [ptts_pkg::ID_W-1:0] id,
                          input logic [ptts_pkg::PERIOD_W-1:0] per,
                          input logic hv);
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.task_id       <= id;
    in_ch.period        <= per;
    in_ch.handler_valid <= hv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Mostly short periods so countdowns expire often; now and then a wide one.
  function automatic logic [ptts_pkg::PERIOD_W-1:0] pick_period();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return ptts_pkg::PERIOD_W'($urandom_range(0, 6));
    if (sel < 95) return ptts_pkg::PERIOD_W'($urandom());
    return (sel[0]) ? '1 : '0;
  endfunction

  initial begin
    int            n_sent;
    int            sel;
    ptts_pkg::op_t op;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= ptts_pkg::OP_TICK;
    in_ch.task_id       <= '0;
    in_ch.period        <= '0;
    in_ch.handler_valid <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    issue_op(ptts_pkg::OP_TICK,   3'd0, 16'h0000, 1'b0);  // empty table: not-due word
    issue_op(ptts_pkg::OP_CREATE, 3'd0, 16'h0000, 1'b1);  // period zero: due every tick
    issue_op(ptts_pkg::OP_CREATE, 3'd7, 16'hFFFF, 1'b1);  // widest period
    issue_op(ptts_pkg::OP_CREATE, 3'd3, 16'h0002, 1'b0);  // no handler: stays absent
    issue_op(ptts_pkg::OP_TICK,   3'd0, 16'h0000, 1'b0);  // 0 and 7 due
    issue_op(ptts_pkg::OP_TICK,   3'd0, 16'h0000, 1'b0);  // 0 due, 7 counts down
    issue_op(ptts_pkg::OP_SUSPEND, 3'd0, 16'h0000, 1'b0);
    issue_op(ptts_pkg::OP_TICK,   3'd0, 16'h0000, 1'b0);  // nothing due
    issue_op(ptts_pkg::OP_RESUME, 3'd0, 16'h0000, 1'b0);
    issue_op(ptts_pkg::OP_SUSPEND, 3'd5, 16'h0000, 1'b0); // suspend an absent entry
    issue_op(ptts_pkg::OP_TICK,   3'd0, 16'h0000, 1'b0);
    // fill the table: tasks 0 to 6 due on one tick, 7 still counts down
    for (int i = 1; i < NUM_TASKS; i++)
      issue_op(ptts_pkg::OP_CREATE, ptts_pkg::ID_W'(i), 16'h0000, 1'b1);
    issue_op(ptts_pkg::OP_TICK,   3'd0, 16'h0000, 1'b0);
    issue_op(ptts_pkg::OP_CREATE, 3'd2, 16'h0000, 1'b0);  // drop a present task
    issue_op(ptts_pkg::OP_DELETE, 3'd7, 16'hFFFF, 1'b1);
    issue_op(OP_SPARE_5, 3'd1, 16'hFFFF, 1'b1);
    issue_op(OP_SPARE_7, 3'd6, 16'h5A5A, 1'b1);
    issue_op(ptts_pkg::OP_TICK,   3'd0, 16'h0000, 1'b0);

    // --- random part ---
    n_sent = 0;
    while (n_sent < RANDOM_WORDS) begin
      // a long stretch with no idling on either side
      steady <= (n_sent >= 60 && n_sent < 100);
      sel = $urandom_range(0, 99);
      if (sel < 40)      op = ptts_pkg::OP_TICK;
      else if (sel < 65) op = ptts_pkg::OP_CREATE;
      else if (sel < 75) op = ptts_pkg::OP_SUSPEND;
      else if (sel < 85) op = ptts_pkg::OP_RESUME;
      else if (sel < 95) op = ptts_pkg::OP_DELETE;
      else               op = ptts_pkg::op_t'($urandom_range(5, 7));
      issue_op(op, ptts_pkg::ID_W'($urandom_range(0, NUM_TASKS - 1)), pick_period(),
               ($urandom_range(0, 99) < 85));
      n_sent++;
    end
    in_ch.valid <= 1'b0;
    steady      <= 1'b0;

    // let the checker see the last word, then drain
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && words_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
